// ===== hw/rtl/line_rasterizer_core_macros.svh =====
// assertion helpers shared by the rasterizer modules
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// property checked on every clock while out of reset
`define LRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in a cycle implies a property in the next cycle
`define LRC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/lr_pkg.sv =====
`default_nettype none

package lr_pkg;

  // field widths
  localparam int COORD_W    = 12;
  localparam int POS_W      = 13;
  localparam int DEC_W      = 16;
  localparam int STEP_W     = 15;
  localparam int COLOUR_W   = 8;
  localparam int SCREEN_W   = 13;
  localparam int ORIGIN_W   = 12;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // defaults for the top level parameters
  localparam int DEFAULT_COORD_BITS = 12;
  localparam int DEFAULT_CMD_DEPTH  = 2;
  localparam int DEFAULT_OUT_DEPTH  = 2;

  // window size after reset
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN = 2'd0,
    CFG_Y_ORIGIN = 2'd1,
    CFG_WIDTH    = 2'd2,
    CFG_HEIGHT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    mode_t                mode;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic [COLOUR_W-1:0]  red_in;
    logic [COLOUR_W-1:0]  green_in;
    logic [COLOUR_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [SCREEN_W-1:0]  pixel_x;
    logic [SCREEN_W-1:0]  pixel_y;
    logic                 visible;
    logic [COLOUR_W-1:0]  red_out;
    logic [COLOUR_W-1:0]  green_out;
    logic [COLOUR_W-1:0]  blue_out;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0]  x_origin;
    logic [ORIGIN_W-1:0]  y_origin;
    logic [SIZE_W-1:0]    width;
    logic [SIZE_W-1:0]    height;
  } window_t;

  // command from the setup stage to the stepping engine
  typedef struct packed {
    logic                      is_load;
    logic                      swapped;
    logic                      descending;
    logic [POS_W-1:0]          major_pos;
    logic [POS_W-1:0]          major_end;
    logic [POS_W-1:0]          minor_pos;
    logic signed [DEC_W-1:0]   decision;
    logic signed [STEP_W-1:0]  step_diag;
    logic [STEP_W-1:0]         step_straight;
    logic [COLOUR_W-1:0]       red;
    logic [COLOUR_W-1:0]       green;
    logic [COLOUR_W-1:0]       blue;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lr_queue.sv =====
`default_nettype none

module lr_queue #(
  parameter int DEPTH = lr_pkg::DEFAULT_CMD_DEPTH,
  parameter int W     = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  push_data,
  output logic               full,
  input  wire logic          pop,
  output logic [W-1:0]       pop_data,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  // status flags
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lr_front.sv =====
`default_nettype none

module lr_front #(
  parameter int COORD_BITS = lr_pkg::DEFAULT_COORD_BITS
) (
  input  wire logic             in_push,
  input  wire lr_pkg::in_item_t in_data,
  output logic                  in_full,
  output logic                  cmd_push,
  output lr_pkg::cmd_t          cmd_data,
  input  wire logic             cmd_full
);

  localparam int COORD_W = lr_pkg::COORD_W;
  localparam int POS_W   = lr_pkg::POS_W;
  localparam int DEC_W   = lr_pkg::DEC_W;
  localparam int STEP_W  = lr_pkg::STEP_W;
  localparam int USE_W   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] COORD_MASK = {COORD_W{1'b1}} >> (COORD_W - USE_W);

  logic [COORD_W-1:0] a0, b0, a1, b1;
  logic [COORD_W-1:0] adx, ady;
  logic               swap, order;
  logic [COORD_W-1:0] p0, p1, q0, q1;
  logic [COORD_W-1:0] dx, dy;
  logic [COORD_W-1:0] maj_start, maj_end, min_start;
  logic [STEP_W-1:0]  dx2, dy2;

  // accept whenever the command queue has room
  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  // endpoint masking and absolute deltas
  assign a0  = in_data.start_x & COORD_MASK;
  assign b0  = in_data.start_y & COORD_MASK;
  assign a1  = in_data.end_x & COORD_MASK;
  assign b1  = in_data.end_y & COORD_MASK;
  assign adx = (a1 >= a0) ? a1 - a0 : a0 - a1;
  assign ady = (b1 >= b0) ? b1 - b0 : b0 - b1;

  // major axis choice, ties go to x
  assign swap = ady > adx;
  assign p0   = swap ? b0 : a0;
  assign q0   = swap ? a0 : b0;
  assign p1   = swap ? b1 : a1;
  assign q1   = swap ? a1 : b1;
  assign dx   = swap ? ady : adx;
  assign dy   = swap ? adx : ady;

  // order endpoints so the minor coordinate rises
  assign order     = q0 > q1;
  assign maj_start = order ? p1 : p0;
  assign maj_end   = order ? p0 : p1;
  assign min_start = order ? q1 : q0;

  assign dx2 = STEP_W'({dx, 1'b0});
  assign dy2 = STEP_W'({dy, 1'b0});

  // command build
  always_comb begin
    cmd_data               = '0;
    cmd_data.is_load       = (in_data.mode == lr_pkg::MODE_LOAD);
    cmd_data.swapped       = swap;
    cmd_data.descending    = maj_end < maj_start;
    cmd_data.major_pos     = POS_W'(maj_start);
    cmd_data.major_end     = POS_W'(maj_end);
    cmd_data.minor_pos     = POS_W'(min_start);
    cmd_data.decision      = DEC_W'(dy2) - DEC_W'(dx);
    cmd_data.step_diag     = dy2 - dx2;
    cmd_data.step_straight = dy2;
    cmd_data.red           = in_data.red_in;
    cmd_data.green         = in_data.green_in;
    cmd_data.blue          = in_data.blue_in;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lr_back.sv =====
`default_nettype none
`include "line_rasterizer_core_macros.svh"

module lr_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_empty,
  input  wire lr_pkg::cmd_t     cmd_data,
  output logic                  cmd_pop,
  input  wire lr_pkg::window_t  win,
  input  wire logic             out_full,
  output logic                  out_push,
  output lr_pkg::out_item_t     out_data
);

  localparam int POS_W    = lr_pkg::POS_W;
  localparam int DEC_W    = lr_pkg::DEC_W;
  localparam int STEP_W   = lr_pkg::STEP_W;
  localparam int COLOUR_W = lr_pkg::COLOUR_W;
  localparam int SCREEN_W = lr_pkg::SCREEN_W;

  logic                      active_r, active_nxt;
  logic                      swapped_r, swapped_nxt;
  logic                      desc_r, desc_nxt;
  logic [POS_W-1:0]          major_pos_r, major_pos_nxt;
  logic [POS_W-1:0]          major_end_r, major_end_nxt;
  logic [POS_W-1:0]          minor_pos_r, minor_pos_nxt;
  logic signed [DEC_W-1:0]   decision_r, decision_nxt;
  logic signed [STEP_W-1:0]  step_diag_r, step_diag_nxt;
  logic [STEP_W-1:0]         step_straight_r, step_straight_nxt;
  logic [COLOUR_W-1:0]       red_r, red_nxt;
  logic [COLOUR_W-1:0]       green_r, green_nxt;
  logic [COLOUR_W-1:0]       blue_r, blue_nxt;

  logic             take_load, take_step;
  logic [POS_W-1:0] lx, ly;
  logic             last;

  // one command per cycle while the result queue has room
  assign cmd_pop   = !cmd_empty && !out_full;
  assign take_load = cmd_pop && cmd_data.is_load;
  assign take_step = cmd_pop && !cmd_data.is_load && active_r;
  assign out_push  = take_step;

  // current pixel in window axes
  assign lx   = swapped_r ? minor_pos_r : major_pos_r;
  assign ly   = swapped_r ? major_pos_r : minor_pos_r;
  assign last = (major_pos_r == major_end_r);

  // result item
  always_comb begin
    out_data.pixel_x   = SCREEN_W'(lx) + SCREEN_W'(win.x_origin);
    out_data.pixel_y   = SCREEN_W'(ly) + SCREEN_W'(win.y_origin);
    out_data.visible   = (SCREEN_W'(lx) < win.width) && (SCREEN_W'(ly) < win.height);
    out_data.red_out   = red_r;
    out_data.green_out = green_r;
    out_data.blue_out  = blue_r;
    out_data.last      = last;
  end

  // line state update: load replaces, step advances or, at the last pixel, ends the line
  always_comb begin
    active_nxt        = active_r;
    swapped_nxt       = swapped_r;
    desc_nxt          = desc_r;
    major_pos_nxt     = major_pos_r;
    major_end_nxt     = major_end_r;
    minor_pos_nxt     = minor_pos_r;
    decision_nxt      = decision_r;
    step_diag_nxt     = step_diag_r;
    step_straight_nxt = step_straight_r;
    red_nxt           = red_r;
    green_nxt         = green_r;
    blue_nxt          = blue_r;
    if (take_load) begin
      active_nxt        = 1'b1;
      swapped_nxt       = cmd_data.swapped;
      desc_nxt          = cmd_data.descending;
      major_pos_nxt     = cmd_data.major_pos;
      major_end_nxt     = cmd_data.major_end;
      minor_pos_nxt     = cmd_data.minor_pos;
      decision_nxt      = cmd_data.decision;
      step_diag_nxt     = cmd_data.step_diag;
      step_straight_nxt = cmd_data.step_straight;
      red_nxt           = cmd_data.red;
      green_nxt         = cmd_data.green;
      blue_nxt          = cmd_data.blue;
    end else if (take_step) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        if (decision_r > 0) begin
          minor_pos_nxt = minor_pos_r + 1'b1;
          decision_nxt  = decision_r + DEC_W'(step_diag_r);
        end else begin
          decision_nxt  = decision_r + $signed(DEC_W'(step_straight_r));
        end
        major_pos_nxt = desc_r ? major_pos_r - 1'b1 : major_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    swapped_r       <= swapped_nxt;
    desc_r          <= desc_nxt;
    major_pos_r     <= major_pos_nxt;
    major_end_r     <= major_end_nxt;
    minor_pos_r     <= minor_pos_nxt;
    decision_r      <= decision_nxt;
    step_diag_r     <= step_diag_nxt;
    step_straight_r <= step_straight_nxt;
    red_r           <= red_nxt;
    green_r         <= green_nxt;
    blue_r          <= blue_nxt;
  end

  // checks
  `LRC_ASSERT(a_push_has_room, !out_push || !out_full, "result pushed into a full queue")
  `LRC_ASSERT_NEXT(a_load_arms, take_load, active_r, "line load did not arm the engine")
  `LRC_ASSERT_NEXT(a_last_ends, take_step && last, !active_r, "line still active after last pixel")
  `LRC_ASSERT_NEXT(a_major_moves, take_step && !last, (major_pos_r == $past(major_pos_r) + 1'b1) || (major_pos_r == $past(major_pos_r) - 1'b1), "major coordinate did not move by one")

endmodule

`default_nettype wire

// ===== hw/rtl/line_rasterizer_core.sv =====
`default_nettype none

// Bresenham line rasterizer. A load item (mode 0) sets up a line from two window-local
// endpoints and a colour and gives no result; each step item (mode 1) then gives one pixel
// in screen coordinates with a clip flag and a last marker, until the last pixel has been
// given. Items enter and results leave at one per clock unless stalled: the setup stage
// computes the major axis, ordering and error terms of a load combinationally and writes
// a command queue, and the stepping engine retires one command per cycle (one add and
// compare on the error term). An item and its result pass the command and result queue
// registers; the output side stalls only when its queue is full. Configuration registers
// may be written while no item is in flight; the write port is always ready.
module line_rasterizer_core #(
  parameter int COORD_BITS = lr_pkg::DEFAULT_COORD_BITS,
  parameter int CMD_DEPTH  = lr_pkg::DEFAULT_CMD_DEPTH,
  parameter int OUT_DEPTH  = lr_pkg::DEFAULT_OUT_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire lr_pkg::in_item_t               in_data,
  output logic                                in_full,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output lr_pkg::out_item_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMD_W    = $bits(lr_pkg::cmd_t);
  localparam int OUT_W    = $bits(lr_pkg::out_item_t);
  localparam int ORIGIN_W = lr_pkg::ORIGIN_W;
  localparam int SIZE_W   = lr_pkg::SIZE_W;

  lr_pkg::window_t   window_r, window_nxt;
  lr_pkg::cmd_t      front_cmd, back_cmd;
  lr_pkg::out_item_t back_out;
  logic [OUT_W-1:0]  out_bits;
  logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic              res_push, res_full;

  // window registers
  assign cfg_ready = 1'b1;

  always_comb begin
    window_nxt = window_r;
    if (cfg_valid) begin
      unique case (lr_pkg::cfg_reg_t'(cfg_index))
        lr_pkg::CFG_X_ORIGIN: window_nxt.x_origin = cfg_data[ORIGIN_W-1:0];
        lr_pkg::CFG_Y_ORIGIN: window_nxt.y_origin = cfg_data[ORIGIN_W-1:0];
        lr_pkg::CFG_WIDTH:    window_nxt.width    = cfg_data[SIZE_W-1:0];
        lr_pkg::CFG_HEIGHT:   window_nxt.height   = cfg_data[SIZE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r.x_origin <= '0;
      window_r.y_origin <= '0;
      window_r.width    <= lr_pkg::RESET_WIDTH;
      window_r.height   <= lr_pkg::RESET_HEIGHT;
    end else begin
      window_r <= window_nxt;
    end
  end

  // setup stage
  lr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (front_cmd),
    .cmd_full (cmd_full)
  );

  // command queue between setup and stepping
  lr_queue #(
    .DEPTH (CMD_DEPTH),
    .W     (CMD_W)
  ) u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .empty     (cmd_empty)
  );

  // stepping engine
  lr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (back_cmd),
    .cmd_pop   (cmd_pop),
    .win       (window_r),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_data  (back_out)
  );

  // result queue
  lr_queue #(
    .DEPTH (OUT_DEPTH),
    .W     (OUT_W)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (back_out),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_bits),
    .empty     (out_empty)
  );

  assign out_data = out_bits;

endmodule

`default_nettype wire
